FILE: rtl/core/mfs_pkg.sv
// Shared types and constants for the multiword flag set.
// Used by the top level and the testbench; no dependencies.
package mfs_pkg;

    // Field widths fixed by the request format
    localparam int MODE_W = 3;
    localparam int IDX_W  = 4;
    localparam int WORD_W = 64;
    localparam int OLEN_W = 5;
    localparam int USED_W = 5;

    // Operation codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD       = 3'd0,
        MODE_REMOVE    = 3'd1,
        MODE_TEST      = 3'd2,
        MODE_CLEAR     = 3'd3,
        MODE_UNION     = 3'd4,
        MODE_DIFF      = 3'd5,
        MODE_INTERSECT = 3'd6,
        MODE_READ      = 3'd7
    } mode_t;

endpackage

FILE: rtl/core/multiword_flag_set_unit.sv
// Multiword flag set: top level with request sequencer and word read-modify-write.
// Depends on mfs_pkg and mfs_ram.
//
// Usage:
//   Requests enter on in_valid/in_ready with mode, word_index, bits,
//   other_length and last_word; each request yields exactly one result on
//   out_valid/out_ready carrying hit, word_out and used_words.
//   The flag words live in a RAM with a registered read; the word
//   count lives in a flip-flop register.
// Sequencing:
//   The accept cycle issues the RAM read; the write-back state then modifies
//   the word, writes it back and presents the result, and the next request
//   is taken only once the block is idle again. An add or union word placed
//   g words beyond the current count first zeroes the gap words one per
//   cycle in the zero state, before the write-back.
//   With the single RAM port pair, one request is in flight at a time.
// Reset:
//   The word count clears and the output is empty. Word storage is not
//   cleared; words beyond the count are never reported.
// Output stall:
//   A finished result waits in the output register while the next request
//   is taken; a further result parks in a holding register and the block
//   stops taking requests until the output drains.
// Notes: other_length and last_word are carried for compatibility and do
// not affect the result.
module multiword_flag_set_unit #(
    parameter int MAX_WORDS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mfs_pkg::MODE_W-1:0]   mode,
    input  logic [mfs_pkg::IDX_W-1:0]    word_index,
    input  logic [mfs_pkg::WORD_W-1:0]   bits,
    input  logic [mfs_pkg::OLEN_W-1:0]   other_length,
    input  logic                         last_word,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic [mfs_pkg::WORD_W-1:0]   word_out,
    output logic [mfs_pkg::USED_W-1:0]   used_words
);
    import mfs_pkg::*;

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam int EW = (CW > IDX_W + 1) ? CW : IDX_W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ZERO = 4'b0010,
        S_RMW  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic                out_valid_reg, out_valid_next;

    mode_t               req_mode_reg, req_mode_next;
    logic [IDX_W-1:0]    req_idx_reg, req_idx_next;
    logic [WORD_W-1:0]   req_bits_reg, req_bits_next;
    logic                hit_reg, hit_next;
    logic [WORD_W-1:0]   word_out_reg, word_out_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic                pend_hit_reg, pend_hit_next;
    logic [WORD_W-1:0]   pend_word_reg, pend_word_next;
    logic [USED_W-1:0]   pend_used_reg, pend_used_next;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [WORD_W-1:0]   ram_rd_data;

    logic [EW-1:0]       req_idx_e;
    logic [EW-1:0]       count_e;
    logic [EW-1:0]       in_idx_e;
    logic                in_use;
    logic                in_range;
    logic                is_last;
    logic [WORD_W-1:0]   new_word;
    logic                res_hit;
    logic [WORD_W-1:0]   res_word;
    logic [CW-1:0]       res_count;
    logic                res_wr;
    logic                out_free;
    logic                gap_needed;

    mfs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS),
        .ADDR_W(AW)
    ) u_word_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(AW'(word_index)),
        .rd_data(ram_rd_data)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign word_out   = word_out_reg;
    assign used_words = used_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign req_idx_e = EW'(req_idx_reg);
    assign count_e   = EW'(count_reg);
    assign in_idx_e  = EW'(word_index);
    assign in_use    = (req_idx_e < count_e);
    assign in_range  = (req_idx_e < EW'(MAX_WORDS));
    assign is_last   = ((req_idx_e + EW'(1)) == count_e);

    // Add or union placed past the count with words in between to zero
    assign gap_needed = ((mode_t'(mode) == MODE_ADD) || (mode_t'(mode) == MODE_UNION))
                        && (in_idx_e < EW'(MAX_WORDS)) && (in_idx_e > count_e);

    // Modify the fetched word and work out the result of the request
    always_comb
    begin
        res_hit   = 1'b0;
        res_word  = '0;
        res_count = count_reg;
        res_wr    = 1'b0;
        new_word  = '0;
        unique case (req_mode_reg) inside
            MODE_ADD, MODE_UNION:
            begin
                if (in_range)
                begin
                    res_wr = 1'b1;
                    if (in_use)
                    begin
                        new_word = ram_rd_data | req_bits_reg;
                    end
                    else
                    begin
                        new_word  = req_bits_reg;
                        res_count = CW'(req_idx_e + EW'(1));
                    end
                    res_word = new_word;
                end
            end
            MODE_REMOVE, MODE_DIFF, MODE_INTERSECT:
            begin
                if (req_mode_reg == MODE_INTERSECT)
                begin
                    new_word = ram_rd_data & req_bits_reg;
                end
                else
                begin
                    new_word = ram_rd_data & ~req_bits_reg;
                end
                if (in_use)
                begin
                    // Trim the count when the last word in use empties
                    if (is_last && (new_word == '0))
                    begin
                        res_count = count_reg - CW'(1);
                    end
                    else
                    begin
                        res_wr   = 1'b1;
                        res_word = new_word;
                    end
                end
            end
            MODE_TEST:
            begin
                res_hit  = in_use && ((ram_rd_data & req_bits_reg) != '0);
                res_word = in_use ? ram_rd_data : '0;
            end
            MODE_CLEAR:
            begin
                res_count = '0;
            end
            MODE_READ:
            begin
                res_word = in_use ? ram_rd_data : '0;
            end
        endcase
    end

    // Sequence the request: fetch, zero gap words, write back, deliver
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        req_mode_next  = req_mode_reg;
        req_idx_next   = req_idx_reg;
        req_bits_next  = req_bits_reg;
        hit_next       = hit_reg;
        word_out_next  = word_out_reg;
        used_next      = used_reg;
        pend_hit_next  = pend_hit_reg;
        pend_word_next = pend_word_reg;
        pend_used_next = pend_used_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = AW'(req_idx_reg);
        ram_wr_data    = new_word;
        ram_rd_en      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_mode_next = mode_t'(mode);
                    req_idx_next  = word_index;
                    req_bits_next = bits;
                    ram_rd_en     = 1'b1;
                    if (gap_needed)
                    begin
                        ptr_next   = AW'(count_reg);
                        state_next = S_ZERO;
                    end
                    else
                    begin
                        state_next = S_RMW;
                    end
                end
            end
            S_ZERO:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ptr_reg;
                ram_wr_data = '0;
                if ((EW'(ptr_reg) + EW'(1)) == req_idx_e)
                begin
                    state_next = S_RMW;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_RMW:
            begin
                ram_wr_en  = res_wr;
                count_next = res_count;
                if (out_free)
                begin
                    hit_next       = res_hit;
                    word_out_next  = res_word;
                    used_next      = USED_W'(res_count);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    pend_hit_next  = res_hit;
                    pend_word_next = res_word;
                    pend_used_next = USED_W'(res_count);
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    hit_next       = pend_hit_reg;
                    word_out_next  = pend_word_reg;
                    used_next      = pend_used_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            req_mode_reg  <= MODE_READ;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            req_mode_reg  <= req_mode_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        req_idx_reg   <= req_idx_next;
        req_bits_reg  <= req_bits_next;
        hit_reg       <= hit_next;
        word_out_reg  <= word_out_next;
        used_reg      <= used_next;
        pend_hit_reg  <= pend_hit_next;
        pend_word_reg <= pend_word_next;
        pend_used_reg <= pend_used_next;
    end

    // Count never passes the storage depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(count_reg) <= EW'(MAX_WORDS))
        else $error("word count beyond storage depth");

    // One request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    // RAM writes only while zeroing or writing back
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> ((state_reg == S_ZERO) || (state_reg == S_RMW)))
        else $error("word RAM written outside a write phase");

    // A parked result only exists while the output is occupied
    a_park_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> out_valid_reg)
        else $error("result parked while output register empty");

endmodule

FILE: rtl/core/mfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; holds the flag words of the multiword flag set.
module mfs_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: tb/flag_set_checker.sv
`timescale 1ns / 1ps
// Result checker for the multiword flag set: keeps its own copy of the flag words
// and word count, predicts each result from accepted requests and compares.
// Depends on mfs_pkg.
module flag_set_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [mfs_pkg::MODE_W-1:0] mode,
    input  logic [mfs_pkg::IDX_W-1:0]  word_index,
    input  logic [mfs_pkg::WORD_W-1:0] bits,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       hit,
    input  logic [mfs_pkg::WORD_W-1:0] word_out,
    input  logic [mfs_pkg::USED_W-1:0] used_words,
    output int                         fail_count,
    output int                         results_due
);
    import mfs_pkg::*;

    localparam int SET_DEPTH = 16;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] word;
        logic [USED_W-1:0] used;
    } set_view_t;

    logic [WORD_W-1:0] shadow_words [SET_DEPTH];
    logic [USED_W-1:0] shadow_used = '0;
    set_view_t         views_due [$];
    int                mismatches = 0;

    // Write a word in use; drop the last word from the count when it goes to zero
    task automatic store_or_trim(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] nv);
        if ({1'b0, idx} + 5'd1 == shadow_used && nv == '0)
            shadow_used = shadow_used - 5'd1;
        else
            shadow_words[idx] = nv;
    endtask

    // Apply one request to the shadow set and return what the block should report
    task automatic advance_flag_set(input mode_t op, input logic [IDX_W-1:0] idx,
                                    input logic [WORD_W-1:0] value, output set_view_t view);
        logic in_use;
        in_use = {1'b0, idx} < shadow_used;
        view.hit = 1'b0;
        case (op)
            MODE_ADD, MODE_UNION:
            begin
                if (!in_use)
                begin
                    for (int k = int'(shadow_used); k < int'(idx); k++)
                        shadow_words[k] = '0;
                    shadow_words[idx] = value;
                    shadow_used = {1'b0, idx} + 5'd1;
                end
                else
                begin
                    shadow_words[idx] = shadow_words[idx] | value;
                end
            end
            MODE_REMOVE, MODE_DIFF:
            begin
                if (in_use)
                    store_or_trim(idx, shadow_words[idx] & ~value);
            end
            MODE_TEST:
                view.hit = in_use && ((shadow_words[idx] & value) != '0);
            MODE_CLEAR:
                shadow_used = '0;
            MODE_INTERSECT:
            begin
                if (in_use)
                    store_or_trim(idx, shadow_words[idx] & value);
            end
            default:
                ;
        endcase
        view.word = ({1'b0, idx} < shadow_used) ? shadow_words[idx] : '0;
        view.used = shadow_used;
    endtask

    // Match results leaving the block against predictions, then predict new requests
    always @(posedge clk or negedge rst_n)
    begin
        set_view_t view;
        set_view_t due;
        if (!rst_n)
        begin
            for (int k = 0; k < SET_DEPTH; k++)
                shadow_words[k] = '0;
            shadow_used = '0;
            views_due.delete();
            fail_count <= mismatches;
            results_due <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (views_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display({"checker %0t: result with no request pending: ",
                                  "hit %0b word %h used %0d"},
                                 $realtime, hit, word_out, used_words);
                end
                else
                begin
                    due = views_due.pop_front();
                    if (due.hit !== hit || due.word !== word_out || due.used !== used_words)
                    begin
                        mismatches++;
                        if (mismatches <= SHOWN_MISMATCHES)
                            $display({"checker %0t: mismatch (expected/actual) hit %0b/%0b ",
                                      "word %h/%h used %0d/%0d"}, $realtime,
                                     due.hit, hit, due.word, word_out, due.used, used_words);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                advance_flag_set(mode_t'(mode), word_index, bits, view);
                views_due.push_back(view);
            end
            fail_count <= mismatches;
            results_due <= views_due.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the multiword flag set: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on mfs_pkg and flag_set_checker.
module tb;
    import mfs_pkg::*;

    localparam int REQUEST_TARGET = 1150;
    localparam int DRAIN_CYCLES = 24;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [MODE_W-1:0] mode = '0;
    logic [IDX_W-1:0]  word_index = '0;
    logic [WORD_W-1:0] bits = '0;
    logic [OLEN_W-1:0] other_length = '0;
    logic              last_word = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              hit;
    logic [WORD_W-1:0] word_out;
    logic [USED_W-1:0] used_words;
    int                fail_count;
    int                results_due;
    int                requests_sent = 0;
    int                burst_left = 0;

    multiword_flag_set_unit #(.MAX_WORDS(16)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .word_index   (word_index),
        .bits         (bits),
        .other_length (other_length),
        .last_word    (last_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .word_out     (word_out),
        .used_words   (used_words)
    );

    flag_set_checker flag_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .word_index  (word_index),
        .bits        (bits),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .word_out    (word_out),
        .used_words  (used_words),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Mix of dense, sparse, single-bit and extreme flag patterns
    function automatic logic [WORD_W-1:0] pick_bits();
        logic [WORD_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            3, 4:    return r & {$urandom, $urandom} & {$urandom, $urandom};
            default: return r;
        endcase
    endfunction

    function automatic logic [OLEN_W-1:0] any_len();
        return OLEN_W'($urandom_range(0, 16));
    endfunction

    // Offer one request in bursts with random gaps; hold it until accepted
    task automatic send_req(input mode_t op, input logic [IDX_W-1:0] idx,
                            input logic [WORD_W-1:0] value, input logic [OLEN_W-1:0] olen,
                            input logic is_last);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                9:          gap = $urandom_range(13, 40);
                default:    gap = $urandom_range(1, 12);
            endcase
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        mode         <= op;
        word_index   <= idx;
        bits         <= value;
        other_length <= olen;
        last_word    <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    // Receiver: rotating stall pattern, plus long hold-offs to back the block up
    initial
    begin
        int          cyc;
        int          hold;
        logic [15:0] pattern;
        cyc = 0;
        hold = 0;
        pattern = 16'hFFFF;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (cyc == 300 || cyc == 1500)
            begin
                hold = 150;
                out_ready <= 1'b0;
            end
            else
            begin
                if (cyc % 64 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       pattern = 16'hFFFF;
                        1:       pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
                        default: pattern = 16'($urandom) | 16'h0001;
                    endcase
                end
                out_ready <= pattern[cyc % 16];
            end
        end
    end

    // Reset, directed requests, random streams and the verdict
    initial
    begin
        int pick;
        int len;
        int start;
        mode_t op;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty set: read, test and remove beyond the count
        send_req(MODE_READ, 4'd0, '1, any_len(), 1'b0);
        send_req(MODE_TEST, 4'd0, '1, any_len(), 1'b1);
        send_req(MODE_REMOVE, 4'd3, '1, any_len(), 1'b0);
        // Grow from empty, then jump to the top word and zero the gap
        send_req(MODE_ADD, 4'd0, 64'h8000_0000_0000_0001, 5'd16, 1'b1);
        send_req(MODE_ADD, 4'd15, '1, 5'd0, 1'b0);
        send_req(MODE_TEST, 4'd15, 64'h8000_0000_0000_0000, any_len(), 1'b1);
        send_req(MODE_TEST, 4'd7, '1, any_len(), 1'b0);
        send_req(MODE_ADD, 4'd7, '0, any_len(), 1'b1);
        send_req(MODE_ADD, 4'd0, 64'h2, any_len(), 1'b0);
        send_req(MODE_READ, 4'd0, '0, any_len(), 1'b1);
        // Trim the last word by remove and by intersect
        send_req(MODE_REMOVE, 4'd15, '1, any_len(), 1'b0);
        send_req(MODE_READ, 4'd15, '1, any_len(), 1'b1);
        send_req(MODE_INTERSECT, 4'd14, '0, any_len(), 1'b0);
        send_req(MODE_DIFF, 4'd0, 64'h1, any_len(), 1'b1);
        send_req(MODE_UNION, 4'd3, 64'hA5A5_5A5A_F0F0_0F0F, 5'd16, 1'b0);
        send_req(MODE_UNION, 4'd15, 64'h5A5A_A5A5_0F0F_F0F0, 5'd16, 1'b1);
        send_req(MODE_DIFF, 4'd15, '1, any_len(), 1'b0);
        // Zero word below the last stays in use
        send_req(MODE_REMOVE, 4'd5, '1, any_len(), 1'b1);
        send_req(MODE_READ, 4'd5, '1, any_len(), 1'b0);
        send_req(MODE_CLEAR, 4'd9, '1, any_len(), 1'b1);
        send_req(MODE_READ, 4'd3, '0, any_len(), 1'b0);
        send_req(MODE_INTERSECT, 4'd0, '1, any_len(), 1'b1);
        // Adding zero still grows the count; removing it trims back to empty
        send_req(MODE_ADD, 4'd0, '0, any_len(), 1'b0);
        send_req(MODE_REMOVE, 4'd0, 64'h1, any_len(), 1'b1);
        send_req(MODE_TEST, 4'd2, '0, any_len(), 1'b0);

        while (requests_sent < REQUEST_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                // Upward union stream of another set
                len = $urandom_range(1, 16);
                for (int k = 0; k < len; k++)
                    send_req(MODE_UNION, IDX_W'(k), pick_bits(), OLEN_W'(len), k == len - 1);
            end
            else if (pick < 32)
            begin
                // Downward difference stream
                start = $urandom_range(0, 15);
                for (int k = start; k >= 0; k--)
                    send_req(MODE_DIFF, IDX_W'(k), pick_bits(), OLEN_W'(start + 1), k == 0);
            end
            else if (pick < 44)
            begin
                // Downward intersect stream, missing words sent as zero
                start = $urandom_range(0, 15);
                len = $urandom_range(0, start + 1);
                for (int k = start; k >= 0; k--)
                    send_req(MODE_INTERSECT, IDX_W'(k), (k < len) ? pick_bits() : '0,
                             OLEN_W'(len), k == 0);
            end
            else if (pick < 50)
            begin
                // Broken union stream: odd start, cut short, stray last flag
                start = $urandom_range(0, 15);
                len = $urandom_range(1, 6);
                for (int k = start; k < start + len && k < 16; k++)
                    send_req(MODE_UNION, IDX_W'(k), pick_bits(), any_len(), 1'($urandom));
            end
            else if (pick < 94)
            begin
                // Single operation, clears kept rare
                op = mode_t'($urandom_range(0, 7));
                if (op == MODE_CLEAR && $urandom_range(0, 3) != 0)
                    op = MODE_TEST;
                send_req(op, IDX_W'($urandom_range(0, 15)), pick_bits(), any_len(),
                         1'($urandom));
            end
            else
            begin
                // Noise: every field random
                send_req(mode_t'($urandom_range(0, 7)), IDX_W'($urandom), {$urandom, $urandom},
                         any_len(), 1'($urandom));
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mfs_pkg.sv
rtl/core/mfs_ram.sv
rtl/core/multiword_flag_set_unit.sv
tb/flag_set_checker.sv
tb/tb.sv
